@@ rtl/clws_pkg.sv @@
// shared constants and types for the character lcd write sequencer
package clws_pkg;

    localparam int LINE_WIDTH_DEF = 20;
    localparam int MAX_DIGITS_DEF = 10;
    localparam int NUM_W          = 32;
    localparam int ADDR_W         = 4;
    localparam int DATA_W         = 32;

    localparam logic [2:0] MODE_CHAR    = 3'd0;
    localparam logic [2:0] MODE_COMMAND = 3'd1;
    localparam logic [2:0] MODE_GOTO    = 3'd2;
    localparam logic [2:0] MODE_NUMBER  = 3'd3;
    localparam logic [2:0] MODE_CLEAR   = 3'd4;
    localparam logic [2:0] MODE_HOME    = 3'd5;

    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_HOME       = 8'h02;
    localparam logic [7:0] CMD_SET_ADDR   = 8'h80;
    localparam logic [7:0] ASCII_ZERO     = 8'h30;
    localparam logic [7:0] NIBBLE_HI_MASK = 8'hF0;
    localparam logic [7:0] NIBBLE_LO_MASK = 8'h0F;

    localparam logic [1:0] REG_BUS_EIGHT  = 2'd0;
    localparam logic [1:0] REG_ROW_ONE    = 2'd1;
    localparam logic [1:0] REG_ROW_TWO    = 2'd2;
    localparam logic [1:0] REG_ROW_THREE  = 2'd3;

    localparam logic [6:0] ROW_ONE_RESET   = 7'd64;
    localparam logic [6:0] ROW_TWO_RESET   = 7'd20;
    localparam logic [6:0] ROW_THREE_RESET = 7'd84;

    typedef struct packed {
        logic       bus_eight_bit;
        logic [6:0] row_one_base;
        logic [6:0] row_two_base;
        logic [6:0] row_three_base;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] value;
    } t_conv_req;

    typedef struct packed {
        logic       done;
        logic [3:0] digit;
    } t_conv_rsp;

endpackage

@@ rtl/clws_dabble.sv @@
// shift-and-add-three binary to decimal converter, one bit per cycle
module clws_dabble #(
    parameter int MAX_DIGITS = clws_pkg::MAX_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  clws_pkg::t_conv_req           i_req,
    input  logic [$clog2(MAX_DIGITS)-1:0] i_idx,
    output clws_pkg::t_conv_rsp           o_rsp
);

    localparam int CNT_W = $clog2(clws_pkg::NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(clws_pkg::NUM_W - 1);

    logic [clws_pkg::NUM_W-1:0] r_bin;
    logic [3:0]                 r_bcd [MAX_DIGITS];
    logic [3:0]                 adj   [MAX_DIGITS];
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;

    always_comb begin
        for (int k = 0; k < MAX_DIGITS; k++) begin
            adj[k] = (r_bcd[k] >= 4'd5) ? (r_bcd[k] + 4'd3) : r_bcd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_bin <= i_req.value;
            for (int k = 0; k < MAX_DIGITS; k++) begin
                r_bcd[k] <= 4'd0;
            end
        end else if (r_busy) begin
            r_bin    <= {r_bin[clws_pkg::NUM_W-2:0], 1'b0};
            r_bcd[0] <= {adj[0][2:0], r_bin[clws_pkg::NUM_W-1]};
            for (int k = 1; k < MAX_DIGITS; k++) begin
                r_bcd[k] <= {adj[k][2:0], adj[k-1][3]};
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.digit = r_bcd[i_idx];

endmodule

@@ rtl/clws_seq.sv @@
// request sequencer: cursor tracking, digit walk, line wrap and bus transfer output
module clws_seq #(
    parameter int LINE_WIDTH = clws_pkg::LINE_WIDTH_DEF,
    parameter int MAX_DIGITS = clws_pkg::MAX_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  clws_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [2:0]                    i_mode,
    input  logic [7:0]                    i_byte_value,
    input  logic [clws_pkg::NUM_W-1:0]    i_number_value,
    input  logic [2:0]                    i_line_index,
    input  logic [5:0]                    i_column_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_register_select,
    output logic [7:0]                    o_bus_value,
    output logic                          o_last_transfer,
    output clws_pkg::t_conv_req           o_conv_req,
    input  clws_pkg::t_conv_rsp           i_conv_rsp,
    output logic [$clog2(MAX_DIGITS)-1:0] o_digit_idx
);

    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(MAX_DIGITS - 1);
    localparam logic [7:0] LW1    = 8'(LINE_WIDTH);
    localparam logic [7:0] LW2    = 8'(2 * LINE_WIDTH);
    localparam logic [7:0] LW3    = 8'(3 * LINE_WIDTH);
    localparam logic [5:0] LW_COL = 6'(LINE_WIDTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_SKIP  = 3'd2;
    localparam logic [2:0] S_DIGIT = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_WRAP  = 3'd5;

    logic [2:0]       r_state,   n_state;
    logic [7:0]       r_cursor,  n_cursor;
    logic [7:0]       r_byte,    n_byte;
    logic             r_rs,      n_rs;
    logic             r_half,    n_half;
    logic             r_more,    n_more;
    logic             r_is_char, n_is_char;
    logic             r_is_num,  n_is_num;
    logic [IDX_W-1:0] r_idx,     n_idx;
    logic             r_out_valid, n_out_valid;
    logic             r_out_rs,    n_out_rs;
    logic [7:0]       r_out_bus,   n_out_bus;
    logic             r_out_last,  n_out_last;

    logic [7:0] cursor_inc;
    logic [1:0] wrap_row;
    logic       digits_left;
    logic       out_free;
    logic       byte_done;
    logic       goto_ok;

    function automatic logic [7:0] set_addr(input clws_pkg::t_cfg cfg,
                                            input logic [1:0] line,
                                            input logic [5:0] col);
        logic [6:0] base;
        case (line)
            2'd0: begin
                base = 7'd0;
            end
            2'd1: begin
                base = cfg.row_one_base;
            end
            2'd2: begin
                base = cfg.row_two_base;
            end
            default: begin
                base = cfg.row_three_base;
            end
        endcase
        return clws_pkg::CMD_SET_ADDR + {1'b0, base} + {2'b00, col};
    endfunction

    assign cursor_inc  = (r_cursor == 8'hFF) ? r_cursor : (r_cursor + 8'd1);
    assign wrap_row    = (cursor_inc == LW1) ? 2'd1 :
                         (cursor_inc == LW2) ? 2'd2 :
                         (cursor_inc == LW3) ? 2'd3 : 2'd0;
    assign digits_left = r_is_num && (r_idx != '0);
    assign out_free    = !r_out_valid || !i_stall;
    assign byte_done   = i_cfg.bus_eight_bit || r_half;
    assign goto_ok     = !i_line_index[2] && (i_column_index < LW_COL);

    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_byte      = r_byte;
        n_rs        = r_rs;
        n_half      = r_half;
        n_more      = r_more;
        n_is_char   = r_is_char;
        n_is_num    = r_is_num;
        n_idx       = r_idx;
        n_out_valid = out_free ? 1'b0 : r_out_valid;
        n_out_rs    = r_out_rs;
        n_out_bus   = r_out_bus;
        n_out_last  = r_out_last;
        o_conv_req.start = 1'b0;
        o_conv_req.value = i_number_value;

        case (r_state)
            S_IDLE: begin
                n_half   = 1'b0;
                n_is_num = 1'b0;
                if (i_valid) begin
                    case (i_mode)
                        clws_pkg::MODE_CHAR: begin
                            n_byte    = i_byte_value;
                            n_rs      = 1'b1;
                            n_is_char = 1'b1;
                            n_more    = (wrap_row != 2'd0);
                            n_state   = S_EMIT;
                        end
                        clws_pkg::MODE_COMMAND: begin
                            n_byte    = i_byte_value;
                            n_rs      = 1'b0;
                            n_is_char = 1'b0;
                            n_more    = 1'b0;
                            n_state   = S_EMIT;
                        end
                        clws_pkg::MODE_GOTO: begin
                            if (goto_ok) begin
                                n_cursor  = (8'(i_line_index[1:0]) * LW1) + 8'(i_column_index);
                                n_byte    = set_addr(i_cfg, i_line_index[1:0], i_column_index);
                                n_rs      = 1'b0;
                                n_is_char = 1'b0;
                                n_more    = 1'b0;
                                n_state   = S_EMIT;
                            end
                        end
                        clws_pkg::MODE_NUMBER: begin
                            o_conv_req.start = 1'b1;
                            n_is_num  = 1'b1;
                            n_state   = S_CONV;
                        end
                        clws_pkg::MODE_CLEAR: begin
                            n_byte    = clws_pkg::CMD_CLEAR;
                            n_rs      = 1'b0;
                            n_is_char = 1'b0;
                            n_more    = 1'b0;
                            n_cursor  = 8'd0;
                            n_state   = S_EMIT;
                        end
                        clws_pkg::MODE_HOME: begin
                            n_byte    = clws_pkg::CMD_HOME;
                            n_rs      = 1'b0;
                            n_is_char = 1'b0;
                            n_more    = 1'b0;
                            n_cursor  = 8'd0;
                            n_state   = S_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CONV: begin
                if (i_conv_rsp.done) begin
                    n_idx   = IDX_TOP;
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if ((i_conv_rsp.digit == 4'd0) && (r_idx != '0)) begin
                    n_idx = r_idx - 1'b1;
                end else begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                n_byte    = clws_pkg::ASCII_ZERO + {4'd0, i_conv_rsp.digit};
                n_rs      = 1'b1;
                n_is_char = 1'b1;
                n_more    = (wrap_row != 2'd0) || (r_idx != '0);
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_rs    = r_rs;
                    n_out_last  = !r_more && byte_done;
                    if (i_cfg.bus_eight_bit) begin
                        n_out_bus = r_byte;
                    end else if (r_half) begin
                        n_out_bus = r_byte & clws_pkg::NIBBLE_LO_MASK;
                    end else begin
                        n_out_bus = (r_byte & clws_pkg::NIBBLE_HI_MASK) >> 4;
                    end
                    if (byte_done) begin
                        n_half = 1'b0;
                        if (r_is_char) begin
                            n_state = S_WRAP;
                        end else if (digits_left) begin
                            n_idx   = r_idx - 1'b1;
                            n_state = S_DIGIT;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_half = 1'b1;
                    end
                end
            end
            S_WRAP: begin
                n_cursor = cursor_inc;
                if (wrap_row != 2'd0) begin
                    n_byte    = set_addr(i_cfg, wrap_row, 6'd0);
                    n_rs      = 1'b0;
                    n_is_char = 1'b0;
                    n_more    = digits_left;
                    n_state   = S_EMIT;
                end else if (digits_left) begin
                    n_idx   = r_idx - 1'b1;
                    n_state = S_DIGIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= 8'd0;
            r_half      <= 1'b0;
            r_is_num    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_half      <= n_half;
            r_is_num    <= n_is_num;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_rs       <= n_rs;
        r_more     <= n_more;
        r_is_char  <= n_is_char;
        r_idx      <= n_idx;
        r_out_rs   <= n_out_rs;
        r_out_bus  <= n_out_bus;
        r_out_last <= n_out_last;
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_register_select = r_out_rs;
    assign o_bus_value       = r_out_bus;
    assign o_last_transfer   = r_out_last;
    assign o_digit_idx       = r_idx;

endmodule

@@ rtl/char_lcd_write_sequencer.sv @@
// top level of the character lcd write sequencer with its register port
//
// a request transaction (char, command, goto, number, clear, home) enters on
// i_valid/o_stall and becomes a series of bus transfer transactions on
// o_valid/i_stall, each with register select, bus value and a last flag on
// the final transfer of the request. in 4-bit mode every byte goes out as
// two transfers, high nibble first, in bits 3..0.
// one request is worked on at a time; o_stall is high from the cycle after
// acceptance until the sequencer idles again, after the last transfer is in
// the output register (and for chars, the wrap check); an ignored request
// never raises it. char, command, goto, clear and home: the byte is loaded
// into the output register whenever that is free, as two nibbles in 4-bit
// mode; a char that ends a line adds a set-address byte. an ignored goto or
// unused mode gives no transfer. number: the converter turns the 32-bit
// value to decimal by shift-add-3 and pulses done; leading zero digits are
// skipped, keeping at least one, and each digit then goes out as a char.
// a stalled receiver holds the output register and the sequencer waits.
// reset empties the output register, clears the cursor count and loads the
// register defaults (4-bit bus, row bases 64, 20, 84); no clearing pass. the user
// must write registers over the apb-style port only while the block idles; unchecked.
module char_lcd_write_sequencer #(
    parameter int LINE_WIDTH = clws_pkg::LINE_WIDTH_DEF,
    parameter int MAX_DIGITS = clws_pkg::MAX_DIGITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [clws_pkg::ADDR_W-1:0]       paddr,
    input  logic [clws_pkg::DATA_W-1:0]       pwdata,
    output logic [clws_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [2:0]                        i_mode,
    input  logic [7:0]                        i_byte_value,
    input  logic [clws_pkg::NUM_W-1:0]        i_number_value,
    input  logic [2:0]                        i_line_index,
    input  logic [5:0]                        i_column_index,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_register_select,
    output logic [7:0]                        o_bus_value,
    output logic                              o_last_transfer
);

    localparam int IDX_W = $clog2(MAX_DIGITS);

    clws_pkg::t_cfg      r_cfg;
    clws_pkg::t_conv_req conv_req;
    clws_pkg::t_conv_rsp conv_rsp;
    logic [IDX_W-1:0]    digit_idx;
    logic                wr_en;
    logic [1:0]          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bus_eight_bit  <= 1'b0;
            r_cfg.row_one_base   <= clws_pkg::ROW_ONE_RESET;
            r_cfg.row_two_base   <= clws_pkg::ROW_TWO_RESET;
            r_cfg.row_three_base <= clws_pkg::ROW_THREE_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                clws_pkg::REG_BUS_EIGHT: begin
                    r_cfg.bus_eight_bit <= pwdata[0];
                end
                clws_pkg::REG_ROW_ONE: begin
                    r_cfg.row_one_base <= pwdata[6:0];
                end
                clws_pkg::REG_ROW_TWO: begin
                    r_cfg.row_two_base <= pwdata[6:0];
                end
                default: begin
                    r_cfg.row_three_base <= pwdata[6:0];
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            clws_pkg::REG_BUS_EIGHT: begin
                prdata = {{(clws_pkg::DATA_W-1){1'b0}}, r_cfg.bus_eight_bit};
            end
            clws_pkg::REG_ROW_ONE: begin
                prdata = {{(clws_pkg::DATA_W-7){1'b0}}, r_cfg.row_one_base};
            end
            clws_pkg::REG_ROW_TWO: begin
                prdata = {{(clws_pkg::DATA_W-7){1'b0}}, r_cfg.row_two_base};
            end
            default: begin
                prdata = {{(clws_pkg::DATA_W-7){1'b0}}, r_cfg.row_three_base};
            end
        endcase
    end

    clws_dabble #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (conv_req),
        .i_idx   (digit_idx),
        .o_rsp   (conv_rsp)
    );

    clws_seq #(
        .LINE_WIDTH (LINE_WIDTH),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_mode            (i_mode),
        .i_byte_value      (i_byte_value),
        .i_number_value    (i_number_value),
        .i_line_index      (i_line_index),
        .i_column_index    (i_column_index),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_register_select (o_register_select),
        .o_bus_value       (o_bus_value),
        .o_last_transfer   (o_last_transfer),
        .o_conv_req        (conv_req),
        .i_conv_rsp        (conv_rsp),
        .o_digit_idx       (digit_idx)
    );

endmodule

@@ rtl/clws_checker.sv @@
// port-level assertions for the character lcd write sequencer, bound to the top level
module clws_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [2:0] i_mode,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_register_select,
    input logic [7:0] o_bus_value,
    input logic       o_last_transfer
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_register_select) && $stable(o_bus_value)
                               && $stable(o_last_transfer))
        else $error("stalled output transaction changed");

    a_number_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_mode == clws_pkg::MODE_NUMBER) |=> o_stall)
        else $error("number request did not start conversion");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_transfer |-> o_stall)
        else $error("accepting input before request finished");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall && !i_valid && (!o_valid || !i_stall) |=> !o_valid)
        else $error("output transaction with no request pending");

endmodule

bind char_lcd_write_sequencer clws_checker u_clws_checker (.*);

@@ dv/char_lcd_write_sequencer_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the character lcd write sequencer: directed and random requests
module char_lcd_write_sequencer_tb;

    localparam int          LINE_W        = clws_pkg::LINE_WIDTH_DEF;
    localparam int          DIGITS        = clws_pkg::MAX_DIGITS_DEF;
    localparam logic [2:0]  MODE_SPARE_A  = 3'd6;
    localparam logic [2:0]  MODE_SPARE_B  = 3'd7;
    localparam int          RESET_CYCLES  = 5;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          CYCLE_LIMIT   = 2_000_000;
    localparam int          REPORT_LIMIT  = 10;
    localparam logic [31:0] NUMBER_MAX    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic       register_select;
        logic [7:0] bus_value;
        logic       last_transfer;
    } t_lcd_transfer;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  byte_value;
        logic [31:0] number_value;
        logic [2:0]  line_index;
        logic [5:0]  column_index;
    } t_lcd_request;

    class lcd_transfer_scoreboard;
        logic          bus_eight_bit;
        logic [6:0]    row_base [1:3];
        logic [7:0]    cursor_count;
        t_lcd_transfer pending [$];
        int            failures;

        function new();
            bus_eight_bit = 1'b0;
            row_base[1]   = clws_pkg::ROW_ONE_RESET;
            row_base[2]   = clws_pkg::ROW_TWO_RESET;
            row_base[3]   = clws_pkg::ROW_THREE_RESET;
            cursor_count  = '0;
            failures      = 0;
        endfunction

        function void set_register(logic [1:0] index, logic [31:0] value);
            case (index)
                clws_pkg::REG_BUS_EIGHT: bus_eight_bit = value[0];
                clws_pkg::REG_ROW_ONE:   row_base[1]   = value[6:0];
                clws_pkg::REG_ROW_TWO:   row_base[2]   = value[6:0];
                clws_pkg::REG_ROW_THREE: row_base[3]   = value[6:0];
                default: ;
            endcase
        endfunction

        function void queue_byte(logic rs, logic [7:0] data);
            if (bus_eight_bit) begin
                pending.push_back('{rs, data, 1'b0});
            end else begin
                pending.push_back('{rs, (data & clws_pkg::NIBBLE_HI_MASK) >> 4, 1'b0});
                pending.push_back('{rs, data & clws_pkg::NIBBLE_LO_MASK, 1'b0});
            end
        endfunction

        function void move_cursor(logic [2:0] line, logic [5:0] column);
            logic [7:0] addr;
            if (line > 3 || column >= LINE_W)
                return;
            case (line)
                3'd0:    addr = {2'b00, column};
                3'd1:    addr = {1'b0, row_base[1]} + {2'b00, column};
                3'd2:    addr = {1'b0, row_base[2]} + {2'b00, column};
                default: addr = {1'b0, row_base[3]} + {2'b00, column};
            endcase
            cursor_count = 8'(line * LINE_W + column);
            queue_byte(1'b0, clws_pkg::CMD_SET_ADDR + addr);
        endfunction

        function void queue_char(logic [7:0] ch);
            queue_byte(1'b1, ch);
            if (cursor_count != 8'hFF)
                cursor_count++;
            if (cursor_count == LINE_W)
                move_cursor(3'd1, 6'd0);
            else if (cursor_count == 2 * LINE_W)
                move_cursor(3'd2, 6'd0);
            else if (cursor_count == 3 * LINE_W)
                move_cursor(3'd3, 6'd0);
        endfunction

        function void note_request(t_lcd_request req);
            int            start_size;
            int            n;
            logic [31:0]   remain;
            logic [3:0]    digits [DIGITS];
            t_lcd_transfer tail;
            start_size = pending.size();
            case (req.mode)
                clws_pkg::MODE_CHAR:    queue_char(req.byte_value);
                clws_pkg::MODE_COMMAND: queue_byte(1'b0, req.byte_value);
                clws_pkg::MODE_GOTO:    move_cursor(req.line_index, req.column_index);
                clws_pkg::MODE_NUMBER: begin
                    remain = req.number_value;
                    n = 0;
                    do begin
                        digits[n] = 4'(remain % 10);
                        remain = remain / 10;
                        n++;
                    end while (remain != 0 && n < DIGITS);
                    while (n > 0) begin
                        n--;
                        queue_char(clws_pkg::ASCII_ZERO + digits[n]);
                    end
                end
                clws_pkg::MODE_CLEAR: begin
                    queue_byte(1'b0, clws_pkg::CMD_CLEAR);
                    cursor_count = '0;
                end
                clws_pkg::MODE_HOME: begin
                    queue_byte(1'b0, clws_pkg::CMD_HOME);
                    cursor_count = '0;
                end
                default: ;
            endcase
            if (pending.size() > start_size) begin
                tail = pending.pop_back();
                tail.last_transfer = 1'b1;
                pending.push_back(tail);
            end
        endfunction

        function void report(string what, t_lcd_transfer want, t_lcd_transfer seen);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display(
                    "%0t %s: expected rs=%0b bus=%02h last=%0b, got rs=%0b bus=%02h last=%0b",
                    $time, what, want.register_select, want.bus_value,
                    want.last_transfer, seen.register_select, seen.bus_value,
                    seen.last_transfer);
        endfunction

        function void check_transfer(t_lcd_transfer seen);
            t_lcd_transfer want;
            if (pending.size() == 0) begin
                report("transfer with nothing expected", '0, seen);
                return;
            end
            want = pending.pop_front();
            if (seen.register_select !== want.register_select ||
                seen.bus_value !== want.bus_value ||
                seen.last_transfer !== want.last_transfer)
                report("transfer mismatch", want, seen);
        endfunction

        function void flush_leftovers();
            while (pending.size() != 0)
                report("transfer never seen", pending.pop_front(), '0);
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [clws_pkg::ADDR_W-1:0]   paddr;
    logic [clws_pkg::DATA_W-1:0]   pwdata;
    logic [clws_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          i_valid;
    logic                          o_stall;
    logic [2:0]                    i_mode;
    logic [7:0]                    i_byte_value;
    logic [clws_pkg::NUM_W-1:0]    i_number_value;
    logic [2:0]                    i_line_index;
    logic [5:0]                    i_column_index;
    logic                          o_valid;
    logic                          i_stall;
    logic                          o_register_select;
    logic [7:0]                    o_bus_value;
    logic                          o_last_transfer;

    lcd_transfer_scoreboard sb;
    int src_gap_pct;
    int sink_gap_pct;
    int cycle_count = 0;

    char_lcd_write_sequencer DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_mode            (i_mode),
        .i_byte_value      (i_byte_value),
        .i_number_value    (i_number_value),
        .i_line_index      (i_line_index),
        .i_column_index    (i_column_index),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_register_select (o_register_select),
        .o_bus_value       (o_bus_value),
        .o_last_transfer   (o_last_transfer)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("char_lcd_write_sequencer verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_stall <= (sink_gap_pct != 0) && ($urandom_range(99) < sink_gap_pct);
    end

    // each output transaction is checked against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_transfer('{o_register_select, o_bus_value, o_last_transfer});
    end

    function automatic t_lcd_request make_request(logic [2:0] mode, logic [7:0] byte_value,
                                                  logic [31:0] number_value,
                                                  logic [2:0] line, logic [5:0] column);
        t_lcd_request req;
        req.mode         = mode;
        req.byte_value   = byte_value;
        req.number_value = number_value;
        req.line_index   = line;
        req.column_index = column;
        return req;
    endfunction

    function automatic t_lcd_request random_request(logic [2:0] mode);
        return make_request(mode, 8'($urandom_range(255)), $urandom,
                            3'($urandom_range(7)), 6'($urandom_range(63)));
    endfunction

    function automatic bit is_ignored(t_lcd_request req);
        return req.mode == MODE_SPARE_A || req.mode == MODE_SPARE_B ||
               (req.mode == clws_pkg::MODE_GOTO &&
                (req.line_index > 3 || req.column_index >= LINE_W));
    endfunction

    task automatic send_request(t_lcd_request req);
        while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid        = 1'b1;
        i_mode         = req.mode;
        i_byte_value   = req.byte_value;
        i_number_value = req.number_value;
        i_line_index   = req.line_index;
        i_column_index = req.column_index;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(req);
    endtask

    task automatic pause_sender();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
    endtask

    // ignored gotos and unused modes give no transfers, so let the block settle too
    task automatic wait_idle();
        pause_sender();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(index, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(logic bus8, logic [6:0] row1, logic [6:0] row2, logic [6:0] row3);
        write_register(clws_pkg::REG_BUS_EIGHT, {31'd0, bus8});
        write_register(clws_pkg::REG_ROW_ONE, {25'd0, row1});
        write_register(clws_pkg::REG_ROW_TWO, {25'd0, row2});
        write_register(clws_pkg::REG_ROW_THREE, {25'd0, row3});
    endtask

    task automatic run_directed();
        send_request(make_request(clws_pkg::MODE_CLEAR, 8'h00, 32'd0, 3'd0, 6'd0));
        send_request(make_request(clws_pkg::MODE_CHAR, 8'h00, 32'd0, 3'd0, 6'd0));
        send_request(make_request(clws_pkg::MODE_CHAR, 8'hFF, 32'd0, 3'd0, 6'd0));
        send_request(make_request(clws_pkg::MODE_COMMAND, 8'h00, 32'd0, 3'd0, 6'd0));
        send_request(make_request(clws_pkg::MODE_COMMAND, 8'hFF, 32'd0, 3'd0, 6'd0));
        send_request(make_request(clws_pkg::MODE_GOTO, 8'h00, 32'd0, 3'd0, 6'd0));
        send_request(make_request(clws_pkg::MODE_GOTO, 8'h00, 32'd0, 3'd3, 6'(LINE_W - 1)));
        send_request(make_request(clws_pkg::MODE_GOTO, 8'h00, 32'd0, 3'd4, 6'd0));
        send_request(make_request(clws_pkg::MODE_GOTO, 8'hFF, NUMBER_MAX, 3'd7, 6'd63));
        send_request(make_request(clws_pkg::MODE_GOTO, 8'h00, 32'd0, 3'd1, 6'(LINE_W)));
        send_request(make_request(clws_pkg::MODE_GOTO, 8'h00, 32'd0, 3'd0, 6'(LINE_W - 1)));
        send_request(make_request(clws_pkg::MODE_CHAR, "A", 32'd0, 3'd0, 6'd0));
        send_request(make_request(clws_pkg::MODE_GOTO, 8'h00, 32'd0, 3'd1, 6'(LINE_W - 2)));
        send_request(make_request(clws_pkg::MODE_NUMBER, 8'h00, 32'd12345, 3'd0, 6'd0));
        send_request(make_request(clws_pkg::MODE_GOTO, 8'h00, 32'd0, 3'd2, 6'(LINE_W - 1)));
        send_request(make_request(clws_pkg::MODE_CHAR, "B", 32'd0, 3'd0, 6'd0));
        send_request(make_request(clws_pkg::MODE_GOTO, 8'h00, 32'd0, 3'd3, 6'(LINE_W - 1)));
        send_request(make_request(clws_pkg::MODE_CHAR, "C", 32'd0, 3'd0, 6'd0));
        send_request(make_request(clws_pkg::MODE_NUMBER, 8'h00, 32'd0, 3'd0, 6'd0));
        send_request(make_request(clws_pkg::MODE_NUMBER, 8'h00, NUMBER_MAX, 3'd0, 6'd0));
        send_request(make_request(clws_pkg::MODE_NUMBER, 8'h00, 32'd1_000_000_000,
                                  3'd0, 6'd0));
        send_request(make_request(clws_pkg::MODE_HOME, 8'h00, 32'd0, 3'd0, 6'd0));
        send_request(make_request(MODE_SPARE_A, 8'h00, 32'd0, 3'd0, 6'd0));
        send_request(make_request(MODE_SPARE_B, 8'hFF, NUMBER_MAX, 3'd7, 6'd63));
    endtask

    // long digit runs walk the cursor through every line end up to saturation
    task automatic saturate_cursor();
        send_request(random_request(clws_pkg::MODE_CLEAR));
        repeat (26) send_request(make_request(clws_pkg::MODE_NUMBER, 8'($urandom_range(255)),
                                              NUMBER_MAX, 3'($urandom_range(7)),
                                              6'($urandom_range(63))));
        repeat (3) send_request(random_request(clws_pkg::MODE_CHAR));
    endtask

    task automatic random_traffic(int count);
        t_lcd_request req;
        int           pick;
        int           done;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                req = random_request(clws_pkg::MODE_CHAR);
            end else if (pick < 40) begin
                req = random_request(clws_pkg::MODE_COMMAND);
            end else if (pick < 55) begin
                req = random_request(clws_pkg::MODE_GOTO);
                if ($urandom_range(3) != 0) begin
                    req.line_index   = 3'($urandom_range(3));
                    req.column_index = 6'($urandom_range(LINE_W - 1));
                end
            end else if (pick < 75) begin
                req = random_request(clws_pkg::MODE_NUMBER);
                req.number_value = $urandom >> $urandom_range(31);
                if ($urandom_range(9) == 0)
                    req.number_value = '0;
            end else if (pick < 80) begin
                req = random_request(clws_pkg::MODE_CLEAR);
            end else if (pick < 85) begin
                req = random_request(clws_pkg::MODE_HOME);
            end else if (pick < 88) begin
                req = random_request($urandom_range(1) ? MODE_SPARE_B : MODE_SPARE_A);
            end else begin
                // text run starting near a line end
                req = random_request(clws_pkg::MODE_GOTO);
                req.line_index   = 3'($urandom_range(3));
                req.column_index = 6'(LINE_W - 1 - $urandom_range(4));
                send_request(req);
                done++;
                repeat ($urandom_range(7, 2)) begin
                    send_request(random_request(clws_pkg::MODE_CHAR));
                    done++;
                end
                continue;
            end
            send_request(req);
            if (!is_ignored(req))
                done++;
            if ($urandom_range(39) == 0)
                pause_sender();
        end
    endtask

    initial begin
        sb             = new();
        src_gap_pct    = 21;
        sink_gap_pct   = 85;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_valid        = 1'b0;
        i_mode         = clws_pkg::MODE_CHAR;
        i_byte_value   = '0;
        i_number_value = '0;
        i_line_index   = '0;
        i_column_index = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        wait_idle();

        configure(1'b0, 7'($urandom_range(127)), 7'($urandom_range(127)),
                  7'($urandom_range(127)));
        saturate_cursor();
        random_traffic(75);
        wait_idle();

        src_gap_pct  = 85;
        sink_gap_pct = 21;
        configure(1'b1, 7'd127, 7'd0, 7'd127);
        random_traffic(100);
        wait_idle();

        src_gap_pct  = 0;
        sink_gap_pct = 0;
        configure(1'($urandom_range(1)), 7'd0, 7'd127, 7'd0);
        random_traffic(100);
        wait_idle();

        sb.flush_leftovers();
        if (sb.failures == 0)
            $display("char_lcd_write_sequencer verification clean");
        else
            $display("char_lcd_write_sequencer verification failed");
        $finish;
    end

endmodule
